// ----- design/dprm_pkg.sv -----
`default_nettype none

package dprm_pkg;

  // Field and register widths
  localparam int unsigned WindowW  = 16;
  localparam int unsigned MppW     = 24;
  localparam int unsigned DebW     = 8;
  localparam int unsigned CountW   = 16;
  localparam int unsigned ElapsedW = 16;
  localparam int unsigned ProdW    = CountW + MppW;
  localparam int unsigned SpeedW   = 50;

  // Configuration channel
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] CfgWindowMs   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMmPerPulse = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDebounceMs = 2'd2;

  localparam logic [WindowW-1:0] WindowRst   = 16'd1000;
  localparam logic [MppW-1:0]    MppRst      = 24'd256;
  localparam logic [DebW-1:0]    DebounceRst = 8'd10;

  // Request to the divider
  typedef struct packed {
    logic               start;
    logic [SpeedW-1:0]  dividend;
    logic [WindowW-1:0] divisor;
  } dprm_div_req_t;

  // Status back from the divider
  typedef struct packed {
    logic              done;
    logic [SpeedW-1:0] quotient;
  } dprm_div_rsp_t;

endpackage

`default_nettype wire

// ----- design/dprm_if.sv -----
`default_nettype none

interface dprm_in_if;
  logic valid;
  logic ready;
  logic tick;
  logic edge_req;

  modport source (output valid, output tick, output edge_req, input ready);
  modport sink   (input valid, input tick, input edge_req, output ready);
endinterface

interface dprm_out_if;
  logic        valid;
  logic        ready;
  logic        speed_valid;
  logic [49:0] speed;

  modport source (output valid, output speed_valid, output speed, input ready);
  modport sink   (input valid, input speed_valid, input speed, output ready);
endinterface

interface dprm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- design/dprm_counters.sv -----
`default_nettype none

module dprm_counters import dprm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic                tick_i,
  input  wire logic                edge_req_i,
  input  wire logic [DebW-1:0]     debounce_i,
  input  wire logic [WindowW-1:0]  window_i,
  output logic      [CountW-1:0]   count_o,
  output logic      [WindowW-1:0]  win_eff_o,
  output logic                     win_end_o
);

  logic [CountW-1:0]   cnt_q, cnt_d, cnt_a;
  logic [DebW-1:0]     ms_q, ms_d, ms_a;
  logic [ElapsedW-1:0] el_q, el_d, el_b;
  logic                edge_hit;

  always_comb begin
    edge_hit = edge_req_i && (ms_q > debounce_i);

    cnt_a = cnt_q;
    ms_a  = ms_q;
    if (edge_hit) begin
      if (cnt_q != '1) begin
        cnt_a = cnt_q + CountW'(1);
      end
      ms_a = '0;
    end

    // The tick is applied after the edge check, both counters saturate.
    ms_d = ms_a;
    el_b = el_q;
    if (tick_i) begin
      if (ms_a != '1) begin
        ms_d = ms_a + DebW'(1);
      end
      if (el_q != '1) begin
        el_b = el_q + ElapsedW'(1);
      end
    end

    win_eff_o = (window_i == '0) ? WindowW'(1) : window_i;
    win_end_o = (el_b >= win_eff_o);

    cnt_d = win_end_o ? '0 : cnt_a;
    el_d  = win_end_o ? '0 : el_b;
    count_o = cnt_a;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ms_q  <= '0;
      el_q  <= '0;
    end else if (accept_i) begin
      cnt_q <= cnt_d;
      ms_q  <= ms_d;
      el_q  <= el_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/dprm_divider.sv -----
`default_nettype none

module dprm_divider import dprm_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire dprm_div_req_t req_i,
  output dprm_div_rsp_t      rsp_o
);

  localparam int unsigned CntW = $clog2(SpeedW + 1);

  logic [CntW-1:0]    cnt_q;
  logic               done_q;
  logic [SpeedW-1:0]  quo_q;
  logic [WindowW-1:0] rem_q, rem_d;
  logic [WindowW-1:0] div_q;
  logic [WindowW:0]   trial;
  logic [WindowW:0]   diff;
  logic               q_bit;

  // Restoring division, one quotient bit per cycle. The dividend is shifted
  // out of the top of the quotient register as the quotient bits come in.
  always_comb begin
    trial = {rem_q, quo_q[SpeedW-1]};
    diff  = trial - {1'b0, div_q};
    q_bit = (trial >= {1'b0, div_q});
    rem_d = q_bit ? diff[WindowW-1:0] : trial[WindowW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= !req_i.start && (cnt_q == CntW'(1));
      if (req_i.start) begin
        cnt_q <= CntW'(SpeedW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      div_q <= req_i.divisor;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[SpeedW-2:0], q_bit};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// ----- design/debounced_pulse_rate_meter_unit.sv -----
// Channel | Direction | Payload
// cfg_i   | in        | index (2 b), data (24 b): window_ms, mm_per_pulse, debounce_ms
// in_i    | in        | tick (1 b), edge_req (1 b)
// out_o   | out       | speed_valid (1 b), speed (50 b, mm/s with 8 fraction bits)
//
// An item that does not close the window has its result in the output register
// on the next cycle. An item that closes the window passes through a multiply,
// a scale by 1000 and the bit-serial divider and waits for the divider to
// finish; a hold state then loads the output register once the output is free.
// Reset restores the register defaults and clears all counters. A stalled
// output holds its transaction and blocks new input only while it is still full.
`default_nettype none

module debounced_pulse_rate_meter_unit import dprm_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dprm_cfg_if.sink    cfg_i,
  dprm_in_if.sink     in_i,
  dprm_out_if.source  out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_DIV,
    ST_HOLD
  } state_e;

  state_e state_q;

  logic [WindowW-1:0] window_q;
  logic [MppW-1:0]    mpp_q;
  logic [DebW-1:0]    debounce_q;

  logic               in_accept;
  logic               out_free;
  logic [CountW-1:0]  count;
  logic [WindowW-1:0] win_eff;
  logic               win_end;

  logic [CountW-1:0]  count_snap_q;
  logic [WindowW-1:0] win_snap_q;
  logic [ProdW-1:0]   prod_q;

  logic               out_valid_q;
  logic               speed_valid_q;
  logic [SpeedW-1:0]  speed_q;

  dprm_div_req_t div_req;
  dprm_div_rsp_t div_rsp;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= WindowRst;
      mpp_q      <= MppRst;
      debounce_q <= DebounceRst;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgWindowMs:   window_q   <= cfg_i.data[WindowW-1:0];
        CfgMmPerPulse: mpp_q      <= cfg_i.data[MppW-1:0];
        CfgDebounceMs: debounce_q <= cfg_i.data[DebW-1:0];
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_accept  = in_i.valid && in_i.ready;

  dprm_counters u_counters (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_accept),
    .tick_i     (in_i.tick),
    .edge_req_i (in_i.edge_req),
    .debounce_i (debounce_q),
    .window_i   (window_q),
    .count_o    (count),
    .win_eff_o  (win_eff),
    .win_end_o  (win_end)
  );

  // count * mm_per_pulse * 1000, with the factor 1000 taken as 1024 - 16 - 8.
  always_comb begin
    div_req.start    = (state_q == ST_SCALE);
    div_req.dividend = {prod_q, 10'b0} - SpeedW'({prod_q, 4'b0})
                       - SpeedW'({prod_q, 3'b0});
    div_req.divisor  = win_snap_q;
  end

  dprm_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if ((in_accept && !win_end) || ((state_q == ST_HOLD) && out_free)) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept && win_end) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL:   state_q <= ST_SCALE;
        ST_SCALE: state_q <= ST_DIV;
        ST_DIV: begin
          if (div_rsp.done) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      count_snap_q  <= count;
      win_snap_q    <= win_eff;
      speed_valid_q <= 1'b0;
      speed_q       <= '0;
    end
    if (state_q == ST_MUL) begin
      prod_q <= ProdW'(count_snap_q) * ProdW'(mpp_q);
    end
    if ((state_q == ST_HOLD) && out_free) begin
      speed_valid_q <= 1'b1;
      speed_q       <= div_rsp.quotient;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.speed_valid = speed_valid_q;
  assign out_o.speed       = speed_q;

endmodule

`default_nettype wire
